>>> src/cla_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cla_pkg: shared types and constants of the contiguous line allocator
// Holds the request and result transfer types, status and policy codes,
// the line entry kept in the line RAM and the status bundle of the hole
// tracking unit.
// ----------------------------------------------------------------------------
package cla_pkg;

    localparam int LINES      = 256;
    localparam int LINE_W     = $clog2(LINES);
    localparam int CNT_W      = LINE_W + 1;
    localparam int OWNER_BITS = 16;

    localparam logic [1:0] POLICY_FIRST = 2'd0;
    localparam logic [1:0] POLICY_BEST  = 2'd1;
    localparam logic [1:0] POLICY_WORST = 2'd2;

    localparam logic [1:0] ST_ALLOCATED = 2'd0;
    localparam logic [1:0] ST_NO_SPACE  = 2'd1;
    localparam logic [1:0] ST_RELEASED  = 2'd2;

    localparam logic MODE_ALLOC   = 1'b0;
    localparam logic MODE_RELEASE = 1'b1;

    typedef struct packed {
        logic                  mode;
        logic [OWNER_BITS-1:0] owner;
        logic [CNT_W-1:0]      run_length;
        logic [LINE_W-1:0]     start_line;
    } req_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [LINE_W-1:0] granted_start;
    } rsp_t;

    typedef struct packed {
        logic                  busy;
        logic [OWNER_BITS-1:0] owner;
    } line_t;

    typedef struct packed {
        logic              stop;
        logic              found;
        logic [LINE_W-1:0] pick_start;
    } hole_status_t;

endpackage

>>> src/cla_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cla_ram: generic single write, single read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module cla_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> src/cla_hole_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cla_hole_unit: hole tracker and fit comparator
// Takes one line per step, measures the current hole and keeps the pick
// that the placement policy prefers.
// ----------------------------------------------------------------------------
module cla_hole_unit
    import cla_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              clear,
    input  logic              step,
    input  logic [CNT_W-1:0]  idx,
    input  logic              free,
    input  logic [CNT_W-1:0]  need,
    input  logic [1:0]        policy,
    output hole_status_t      stat
);

    logic [LINE_W-1:0] hole_start_reg;
    logic [CNT_W-1:0]  hole_len_reg;
    logic [LINE_W-1:0] pick_start_reg;
    logic [CNT_W-1:0]  pick_len_reg;
    logic              found_reg;

    logic is_best;
    logic is_worst;
    logic qualify;
    logic take;

    always_comb
    begin
        is_best  = (policy == POLICY_BEST);
        is_worst = (policy == POLICY_WORST);
        qualify  = !free && (hole_len_reg >= need) && (hole_len_reg != '0);
        take     = qualify && (!found_reg
                   || (is_best && (hole_len_reg < pick_len_reg))
                   || (is_worst && (hole_len_reg > pick_len_reg)));
        stat.stop       = qualify && !is_best && !is_worst;
        stat.found      = found_reg;
        stat.pick_start = pick_start_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg      <= 1'b0;
            hole_len_reg   <= '0;
            hole_start_reg <= '0;
            pick_start_reg <= '0;
            pick_len_reg   <= '0;
        end
        else if (clear)
        begin
            found_reg    <= 1'b0;
            hole_len_reg <= '0;
        end
        else if (step)
        begin
            if (free)
            begin
                if (hole_len_reg == '0)
                begin
                    hole_start_reg <= idx[LINE_W-1:0];
                end
                hole_len_reg <= hole_len_reg + 1'b1;
            end
            else
            begin
                if (take)
                begin
                    pick_start_reg <= hole_start_reg;
                    pick_len_reg   <= hole_len_reg;
                    found_reg      <= 1'b1;
                end
                hole_len_reg <= '0;
            end
        end
    end

endmodule

>>> src/contiguous_line_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// contiguous_line_allocator: first, best and worst fit line allocator
// Keeps a busy bit and an owner tag per line; allocates contiguous runs
// and releases owned ranges under a small sequencer.
//
//   channel  handshake              payload
//   -------  ---------------------  ------------------------------
//   request  start, busy            req  (mode, owner, length, start)
//   result   done (one cycle)       rsp  (status, granted_start)
//   config   cfg_valid, cfg_ready   cfg_data (fit policy)
//
// Allocate: a scan of the line map, stopping at the first fitting hole
// under first fit, then the picked lines are marked one at a time. Release:
// lines in range owned by the requester are freed. A zero-length or
// oversized allocate is refused with no space. After reset a clearing pass
// frees every line, with busy high. Results cannot be stalled: done is high
// for one cycle, and busy drops in the cycle after it.
// ----------------------------------------------------------------------------
module contiguous_line_allocator
    import cla_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  req_t       req,
    output logic       done,
    output rsp_t       rsp,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_data
);

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_REL_RUN,
        S_SCAN,
        S_PICK,
        S_MARK,
        S_REPLY
    } state_t;

    state_t state_reg;
    state_t state_next;

    logic [1:0]            policy_reg;
    logic [OWNER_BITS-1:0] owner_reg;
    logic [CNT_W-1:0]      need_reg;
    logic [CNT_W-1:0]      cur_reg;
    logic [CNT_W-1:0]      cur_next;
    logic [CNT_W-1:0]      remain_reg;
    logic [CNT_W-1:0]      remain_next;
    logic                  rd_v_reg;
    logic                  rd_v_next;
    logic [CNT_W-1:0]      rd_addr_reg;
    rsp_t                  rsp_reg;
    rsp_t                  rsp_next;

    logic                  accept;
    logic                  issue;
    logic                  line_free;
    logic                  hole_clear;
    logic                  hole_step;
    logic                  rel_clear;
    logic                  ram_we;
    logic [LINE_W-1:0]     ram_waddr;
    line_t                 ram_wdata;
    line_t                 rd_data;
    hole_status_t          hole_stat;

    assign accept    = start && !busy;
    assign busy      = (state_reg != S_IDLE);
    assign done      = (state_reg == S_REPLY);
    assign rsp       = rsp_reg;
    assign cfg_ready = 1'b1;

    cla_ram #(
        .WIDTH ($bits(line_t)),
        .DEPTH (LINES)
    ) u_line_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (cur_reg[LINE_W-1:0]),
        .rdata (rd_data)
    );

    cla_hole_unit u_hole (
        .clk    (clk),
        .rst_n  (rst_n),
        .clear  (hole_clear),
        .step   (hole_step),
        .idx    (rd_addr_reg),
        .free   (line_free),
        .need   (need_reg),
        .policy (policy_reg),
        .stat   (hole_stat)
    );

    always_comb
    begin
        state_next      = state_reg;
        cur_next        = cur_reg;
        remain_next     = remain_reg;
        rsp_next        = rsp_reg;
        rd_v_next       = 1'b0;
        issue           = 1'b0;
        hole_clear      = 1'b0;
        hole_step       = 1'b0;
        line_free       = (rd_addr_reg < CNT_W'(LINES)) && !rd_data.busy;
        rel_clear       = rd_v_reg && (state_reg == S_REL_RUN) && rd_data.busy
                          && (rd_data.owner == owner_reg);
        ram_we          = rel_clear;
        ram_waddr       = rd_addr_reg[LINE_W-1:0];
        ram_wdata.busy  = 1'b0;
        ram_wdata.owner = '1;

        case (state_reg)
            S_INIT:
            begin
                ram_we    = 1'b1;
                ram_waddr = cur_reg[LINE_W-1:0];
                if (cur_reg == CNT_W'(LINES - 1))
                begin
                    cur_next   = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    cur_next = cur_reg + 1'b1;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    rsp_next.granted_start = '0;
                    if (req.mode == MODE_RELEASE)
                    begin
                        cur_next    = {1'b0, req.start_line};
                        remain_next = req.run_length;
                        state_next  = S_REL_RUN;
                    end
                    else if ((req.run_length == '0) || (req.run_length > CNT_W'(LINES)))
                    begin
                        rsp_next.status = ST_NO_SPACE;
                        state_next      = S_REPLY;
                    end
                    else
                    begin
                        hole_clear = 1'b1;
                        cur_next   = '0;
                        state_next = S_SCAN;
                    end
                end
            end
            S_REL_RUN:
            begin
                if ((remain_reg != '0) && (cur_reg < CNT_W'(LINES)))
                begin
                    issue       = 1'b1;
                    rd_v_next   = 1'b1;
                    cur_next    = cur_reg + 1'b1;
                    remain_next = remain_reg - 1'b1;
                end
                else
                begin
                    rsp_next.status = ST_RELEASED;
                    state_next      = S_REPLY;
                end
            end
            S_SCAN:
            begin
                hole_step = rd_v_reg;
                if (rd_v_reg && (hole_stat.stop || (rd_addr_reg == CNT_W'(LINES))))
                begin
                    state_next = S_PICK;
                end
                else
                begin
                    issue     = 1'b1;
                    rd_v_next = 1'b1;
                    cur_next  = cur_reg + 1'b1;
                end
            end
            S_PICK:
            begin
                if (hole_stat.found)
                begin
                    cur_next    = {1'b0, hole_stat.pick_start};
                    remain_next = need_reg;
                    state_next  = S_MARK;
                end
                else
                begin
                    rsp_next.status = ST_NO_SPACE;
                    state_next      = S_REPLY;
                end
            end
            S_MARK:
            begin
                ram_we          = 1'b1;
                ram_waddr       = cur_reg[LINE_W-1:0];
                ram_wdata.busy  = 1'b1;
                ram_wdata.owner = owner_reg;
                cur_next        = cur_reg + 1'b1;
                remain_next     = remain_reg - 1'b1;
                if (remain_reg == CNT_W'(1))
                begin
                    rsp_next.status        = ST_ALLOCATED;
                    rsp_next.granted_start = hole_stat.pick_start;
                    state_next             = S_REPLY;
                end
            end
            S_REPLY:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_INIT;
            policy_reg <= POLICY_FIRST;
            cur_reg    <= '0;
            rd_v_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cur_reg   <= cur_next;
            rd_v_reg  <= rd_v_next;
            if (cfg_valid && cfg_ready)
            begin
                policy_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        remain_reg <= remain_next;
        rsp_reg    <= rsp_next;
        if (issue)
        begin
            rd_addr_reg <= cur_reg;
        end
        if (accept)
        begin
            owner_reg <= req.owner;
            need_reg  <= req.run_length;
        end
    end

    a_reply_ends: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !busy)
        else $error("reply not followed by idle");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy)
        else $error("accepted request did not start work");

    a_mark_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MARK) |-> (cur_reg < CNT_W'(LINES)))
        else $error("marked line past the end of the map");

    a_read_from_release: assert property (@(posedge clk) disable iff (!rst_n)
        rd_v_reg |-> $past((state_reg == S_REL_RUN) || (state_reg == S_SCAN)))
        else $error("line read outside release sweep or scan");

    a_no_space_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (rsp.status != ST_ALLOCATED)) |-> (rsp.granted_start == '0))
        else $error("granted start set without allocation");

endmodule
